// ===== rtl/decimal_text_to_fixed_point_top_defines.svh =====
// Assertion macros for the decimal text to fixed-point parser.
// Used by decimal_text_to_fixed_point_top; needs clk_i and rst_ni in scope.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dtfp_pkg.sv =====
// Types and character codes for the decimal parser.
// No dependencies.
`default_nettype none

package dtfp_pkg;

  localparam int FD_W = 4;

  localparam logic [FD_W-1:0] FRAC_DIGITS_RST = 4'd2;

  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  typedef struct packed {
    logic            negative;
    logic            bad;
    logic [FD_W-1:0] kept;
    logic [FD_W-1:0] places;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_PAD,
    BK_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/dtfp_front.sv =====
// Front end: classifies characters, accumulates the magnitude, hands a job
// per number to the queue. Depends on dtfp_pkg.
`default_nettype none

module dtfp_front #(
  parameter int VALUE_BITS      = 32,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [7:0]                  char_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic [dtfp_pkg::FD_W-1:0]   cfg_wdata_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output dtfp_pkg::job_ctrl_t         job_ctrl_o,
  output logic [VALUE_BITS-1:0]       job_accum_o
);
  import dtfp_pkg::*;

  localparam logic [VALUE_BITS-1:0] MagLimit = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic [FD_W-1:0]       fd_q;
  logic [VALUE_BITS-1:0] accum_q, accum_d;
  logic                  negative_q, negative_d;
  logic                  first_q, first_d;
  logic                  in_frac_q, in_frac_d;
  logic [FD_W-1:0]       kept_q, kept_d;
  logic                  bad_q, bad_d;

  logic [FD_W-1:0]       places;
  logic [VALUE_BITS+3:0] prod;
  logic                  ovf;
  logic                  accept;

  assign ready_o = !q_full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    if (int'(fd_q) > MAX_FRAC_DIGITS) begin
      places = FD_W'(MAX_FRAC_DIGITS);
    end else begin
      places = fd_q;
    end
  end

  assign prod = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
              + {{VALUE_BITS{1'b0}}, 4'(char_i - CHAR_0)};
  assign ovf  = prod > {4'b0000, MagLimit};

  always_comb begin
    accum_d    = accum_q;
    negative_d = negative_q;
    in_frac_d  = in_frac_q;
    kept_d     = kept_q;
    bad_d      = bad_q;
    first_d    = 1'b0;
    if (char_i >= CHAR_0 && char_i <= CHAR_9) begin
      if (!in_frac_q || kept_q < places) begin
        if (ovf) begin
          bad_d = 1'b1;
        end else begin
          accum_d = prod[VALUE_BITS-1:0];
        end
        if (in_frac_q) begin
          kept_d = kept_q + 1'b1;
        end
      end
    end else if (char_i == CHAR_POINT) begin
      if (in_frac_q) begin
        bad_d = 1'b1;
      end
      in_frac_d = 1'b1;
    end else if ((char_i == CHAR_MINUS || char_i == CHAR_PLUS) && first_q) begin
      negative_d = (char_i == CHAR_MINUS);
    end else begin
      bad_d = 1'b1;
    end
  end

  assign push_o              = accept && last_i;
  assign job_accum_o         = accum_d;
  assign job_ctrl_o.negative = negative_d;
  assign job_ctrl_o.bad      = bad_d;
  assign job_ctrl_o.kept     = kept_d;
  assign job_ctrl_o.places   = places;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q       <= FRAC_DIGITS_RST;
      accum_q    <= '0;
      negative_q <= 1'b0;
      first_q    <= 1'b1;
      in_frac_q  <= 1'b0;
      kept_q     <= '0;
      bad_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fd_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (last_i) begin
          accum_q    <= '0;
          negative_q <= 1'b0;
          first_q    <= 1'b1;
          in_frac_q  <= 1'b0;
          kept_q     <= '0;
          bad_q      <= 1'b0;
        end else begin
          accum_q    <= accum_d;
          negative_q <= negative_d;
          first_q    <= first_d;
          in_frac_q  <= in_frac_d;
          kept_q     <= kept_d;
          bad_q      <= bad_d;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtfp_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on nothing but its width parameter.
`default_nettype none

module dtfp_queue #(
  parameter int DATA_W = 42
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              full_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'd2;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtfp_back.sv =====
// Back end: rescales to the requested places (zero padding with overflow
// check, or division by ten per dropped place), applies sign, holds the result.
// Depends on dtfp_pkg.
`default_nettype none

module dtfp_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  pop_o,
  input  dtfp_pkg::job_ctrl_t   job_ctrl_i,
  input  logic [VALUE_BITS-1:0] job_accum_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  ok_o
);
  import dtfp_pkg::*;

  localparam int MulW = 2 * VALUE_BITS;
  // reciprocal of ten scaled by 2^(VALUE_BITS+3), rounded up
  localparam logic [VALUE_BITS+3:0] Pow2Shift = {1'b1, {(VALUE_BITS+3){1'b0}}};
  localparam logic [VALUE_BITS+3:0] RecipWide =
    (Pow2Shift + (VALUE_BITS+4)'(9)) / (VALUE_BITS+4)'(10);
  localparam logic [VALUE_BITS-1:0] Recip10  = RecipWide[VALUE_BITS-1:0];
  localparam logic [VALUE_BITS-1:0] MagLimit = {1'b1, {(VALUE_BITS-1){1'b0}}};

  back_state_e           state_q, state_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [FD_W-1:0]       step_cnt_q, step_cnt_d;
  logic                  neg_q, neg_d;
  logic                  bad_q, bad_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  ok_q, ok_d;

  logic                  out_free;
  logic                  take_job;
  back_state_e           job_state;
  logic [MulW-1:0]       quot_prod;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS+3:0] prod;
  logic                  pad_ovf;
  logic                  fin_bad;

  assign out_free = !out_valid_q || ready_i;
  assign take_job = q_valid_i && (state_q == BK_IDLE || (state_q == BK_DONE && out_free));
  assign pop_o    = take_job;

  always_comb begin
    if (job_ctrl_i.bad) begin
      job_state = BK_DONE;
    end else if (job_ctrl_i.kept > job_ctrl_i.places) begin
      job_state = BK_DIV;
    end else if (job_ctrl_i.kept < job_ctrl_i.places) begin
      job_state = BK_PAD;
    end else begin
      job_state = BK_DONE;
    end
  end

  assign quot_prod = MulW'(acc_q) * MulW'(Recip10);
  assign quot      = {3'b000, quot_prod[MulW-1:VALUE_BITS+3]};

  assign prod    = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
  assign pad_ovf = prod > {4'b0000, MagLimit};

  assign fin_bad = bad_q || (!neg_q && acc_q > MagLimit - 1'b1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take_job) begin
          state_d = job_state;
        end
      end
      BK_DIV: begin
        if (step_cnt_q == FD_W'(1)) begin
          state_d = BK_DONE;
        end
      end
      BK_PAD: begin
        if (pad_ovf || step_cnt_q == FD_W'(1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (take_job) begin
          state_d = job_state;
        end else if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    acc_d       = acc_q;
    step_cnt_d  = step_cnt_q;
    neg_d       = neg_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && !ready_i;
    value_d     = value_q;
    ok_d        = ok_q;
    unique case (state_q)
      BK_DIV: begin
        acc_d      = quot;
        step_cnt_d = step_cnt_q - 1'b1;
      end
      BK_PAD: begin
        if (pad_ovf) begin
          bad_d = 1'b1;
        end else begin
          acc_d      = prod[VALUE_BITS-1:0];
          step_cnt_d = step_cnt_q - 1'b1;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ok_d        = !fin_bad;
          if (fin_bad) begin
            value_d = '0;
          end else if (neg_q) begin
            value_d = '0 - acc_q;
          end else begin
            value_d = acc_q;
          end
        end
      end
      default: begin
      end
    endcase
    if (take_job) begin
      acc_d = job_accum_i;
      neg_d = job_ctrl_i.negative;
      bad_d = job_ctrl_i.bad;
      if (job_ctrl_i.kept > job_ctrl_i.places) begin
        step_cnt_d = job_ctrl_i.kept - job_ctrl_i.places;
      end else begin
        step_cnt_d = job_ctrl_i.places - job_ctrl_i.kept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    step_cnt_q <= step_cnt_d;
    neg_q      <= neg_d;
    bad_q      <= bad_d;
    value_q    <= value_d;
    ok_q       <= ok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign valid_o = out_valid_q;
  assign value_o = value_q;
  assign ok_o    = ok_q;

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point_top.sv =====
// Decimal text to fixed-point parser, top level. One character request per cycle
// while the job queue has room. The last character queues a job; the back end then
// pads one zero per missing decimal place, or divides by ten once per dropped place
// when frac_digits was lowered mid-number, then registers the result. A new number
// is taken only once the last is done. Async active-low reset; frac_digits resets to 2.
// Depends on dtfp_pkg, dtfp_front, dtfp_queue, dtfp_back and the defines header.
`default_nettype none
`include "decimal_text_to_fixed_point_top_defines.svh"

module decimal_text_to_fixed_point_top #(
  parameter int VALUE_BITS      = 32,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [7:0]                          s_axis_tdata_i,  // [7:0] char_code
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata_o,  // value, zero padded
  output logic [0:0]                          m_axis_tuser_o,  // [0] ok
  input  logic                                cfg_we_i,
  input  logic [dtfp_pkg::FD_W-1:0]           cfg_wdata_i      // frac_digits
);
  import dtfp_pkg::*;

  localparam int TDataW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CtrlW  = $bits(job_ctrl_t);
  localparam int JobW   = CtrlW + VALUE_BITS;

  logic                  push, pop, q_valid, q_full;
  job_ctrl_t             push_ctrl, pop_ctrl;
  logic [VALUE_BITS-1:0] push_accum, pop_accum;
  logic [JobW-1:0]       q_rdata;
  logic [VALUE_BITS-1:0] value;
  logic                  ok;

  dtfp_front #(
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid_i),
    .ready_o     (s_axis_tready_o),
    .char_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_ctrl_o  (push_ctrl),
    .job_accum_o (push_accum)
  );

  dtfp_queue #(
    .DATA_W (JobW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({push_ctrl, push_accum}),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .rdata_o (q_rdata)
  );

  assign pop_ctrl  = job_ctrl_t'(q_rdata[JobW-1:VALUE_BITS]);
  assign pop_accum = q_rdata[VALUE_BITS-1:0];

  dtfp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .pop_o       (pop),
    .job_ctrl_i  (pop_ctrl),
    .job_accum_i (pop_accum),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .value_o     (value),
    .ok_o        (ok)
  );

  assign m_axis_tdata_o = TDataW'(value);
  assign m_axis_tuser_o = ok;

  `DTFP_ASSERT_NOW(a_bad_zero, m_axis_tvalid_o && !ok, value == '0, "invalid result not zero")
  `DTFP_ASSERT_NEXT(a_last_queued, push, q_valid, "number end not queued")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for decimal_text_to_fixed_point_top: results of character requests are checked against an
// in-bench model of the parser, with directed cases, then random numbers over several place settings.
// Depends on dtfp_pkg and the parser RTL.

module testbench;
  import dtfp_pkg::*;

  localparam int VALUE_BITS    = 32;
  localparam int MAX_PLACES    = 9;
  localparam logic [63:0] MAG_LIMIT = 64'd1 << (VALUE_BITS - 1);
  localparam int SETTLE_CYCLES = VALUE_BITS + MAX_PLACES + 8;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PERCENT  = 25;
  localparam int RANDOM_CHARS  = 900;
  localparam int PHASES        = 6;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  ok;
  } fixed_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i  = '0;
  logic                  s_axis_tlast_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [VALUE_BITS-1:0] m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_we_i        = 1'b0;
  logic [FD_W-1:0]       cfg_wdata_i     = '0;

  decimal_text_to_fixed_point_top #(
    .VALUE_BITS      (VALUE_BITS),
    .MAX_FRAC_DIGITS (MAX_PLACES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // model state
  logic [FD_W-1:0] places_reg = FRAC_DIGITS_RST;
  logic [63:0]     mag        = '0;
  bit              neg_sign   = 1'b0;
  bit              at_start   = 1'b1;
  bit              in_frac    = 1'b0;
  int unsigned     kept       = 0;
  bit              text_bad   = 1'b0;

  fixed_result_t   expected_results[$];
  logic [7:0]      text_buf[$];
  int unsigned     chars_sent   = 0;
  int unsigned     mismatches   = 0;
  int unsigned     stall_cycles = 0;
  bit              src_idle_en  = 1'b1;
  bit              sink_idle_en = 1'b1;

  always #2 clk_i = ~clk_i;

  function automatic void push_digit(input logic [63:0] d);
    if (mag > (MAG_LIMIT - d) / 10) begin
      text_bad = 1'b1;
    end else begin
      mag = mag * 10 + d;
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c, input bit last,
                                     output bit produced, output fixed_result_t res);
    int unsigned fd;
    logic [63:0] twos;
    fd = (places_reg > MAX_PLACES) ? MAX_PLACES : places_reg;
    produced = 1'b0;
    res = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      if (!in_frac) begin
        push_digit(64'(c - CHAR_0));
      end else if (kept < fd) begin
        push_digit(64'(c - CHAR_0));
        kept++;
      end
    end else if (c == CHAR_POINT) begin
      if (in_frac) begin
        text_bad = 1'b1;
      end
      in_frac = 1'b1;
    end else if ((c == CHAR_MINUS || c == CHAR_PLUS) && at_start) begin
      neg_sign = (c == CHAR_MINUS);
    end else begin
      text_bad = 1'b1;
    end
    at_start = 1'b0;
    if (last) begin
      while (kept > fd) begin
        mag = mag / 10;
        kept--;
      end
      while (kept < fd && !text_bad) begin
        push_digit(64'd0);
        kept++;
      end
      if (!neg_sign && mag > MAG_LIMIT - 1) begin
        text_bad = 1'b1;
      end
      produced = 1'b1;
      res.ok = !text_bad;
      twos = ~mag + 64'd1;
      if (!text_bad) begin
        res.value = neg_sign ? twos[VALUE_BITS-1:0] : mag[VALUE_BITS-1:0];
      end
      mag      = '0;
      neg_sign = 1'b0;
      at_start = 1'b1;
      in_frac  = 1'b0;
      kept     = 0;
      text_bad = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    fixed_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o !== want.value) begin
          report_mismatch("value", m_axis_tdata_o, want.value);
        end
        if (m_axis_tuser_o[0] !== want.ok) begin
          report_mismatch("ok flag", 32'(m_axis_tuser_o), 32'(want.ok));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= !sink_idle_en || ($urandom_range(99, 0) >= IDLE_PERCENT);
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] code, input bit ends_number);
    bit            produced;
    fixed_result_t res;
    while (src_idle_en && $urandom_range(99, 0) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    s_axis_tlast_i  <= ends_number;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    parse_char(code, ends_number, produced, res);
    if (produced) begin
      expected_results.push_back(res);
    end
    chars_sent++;
  endtask

  task automatic send_buffer(input bit ends_number);
    foreach (text_buf[i]) begin
      send_char(text_buf[i], ends_number && (i == text_buf.size() - 1));
    end
    text_buf.delete();
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      text_buf.push_back(s[i]);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // back end may still be busy on a number whose result is not yet due
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_places(input logic [FD_W-1:0] places);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= places;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    places_reg = places;
  endtask

  task automatic build_random_number();
    int unsigned pick;
    int unsigned n_int;
    int unsigned n_frac;
    int unsigned fd;
    int unsigned pos;
    longint unsigned scale;
    longint unsigned target;
    longint unsigned part;
    logic [7:0] bad_code;
    pick = $urandom_range(99, 0);
    if (pick < 10) begin
      repeat ($urandom_range(4, 1)) text_buf.push_back(8'($urandom_range(255, 0)));
    end else begin
      case ($urandom_range(2, 0))
        1: text_buf.push_back(CHAR_MINUS);
        2: text_buf.push_back(CHAR_PLUS);
        default: ;
      endcase
      if (pick < 25) begin
        // magnitude within a step or two of the signed limit
        fd = (places_reg > MAX_PLACES) ? MAX_PLACES : places_reg;
        scale = 1;
        repeat (fd) scale = scale * 10;
        target = MAG_LIMIT - 2 + $urandom_range(3, 0);
        load_text($sformatf("%0d", target / scale));
        part = target % scale;
        if (fd > 0 || $urandom_range(1, 0)) begin
          text_buf.push_back(CHAR_POINT);
          pos = text_buf.size();
          repeat (fd) begin
            text_buf.insert(pos, 8'(CHAR_0 + part % 10));
            part = part / 10;
          end
          repeat ($urandom_range(2, 0)) text_buf.push_back(8'(CHAR_0 + $urandom_range(9, 0)));
        end
      end else begin
        n_int = ($urandom_range(3, 0) == 0) ? $urandom_range(10, 0) : $urandom_range(4, 0);
        repeat (n_int) text_buf.push_back(8'(CHAR_0 + $urandom_range(9, 0)));
        if ($urandom_range(1, 0)) begin
          text_buf.push_back(CHAR_POINT);
          n_frac = $urandom_range(11, 0);
          repeat (n_frac) text_buf.push_back(8'(CHAR_0 + $urandom_range(9, 0)));
        end
        if (pick < 40) begin
          case ($urandom_range(4, 0))
            0:       bad_code = 8'($urandom_range(255, 0));
            1:       bad_code = CHAR_POINT;
            2:       bad_code = CHAR_MINUS;
            3:       bad_code = CHAR_PLUS;
            default: bad_code = CHAR_SPACE;
          endcase
          pos = $urandom_range(text_buf.size(), 0);
          text_buf.insert(pos, bad_code);
        end
      end
      if (text_buf.size() == 0) begin
        text_buf.push_back(8'(CHAR_0 + $urandom_range(9, 0)));
      end
    end
  endtask

  // two places from reset: truncation, padding, empty numbers
  task automatic test_reset_places();
    load_text("-1.239");
    send_buffer(1'b1);
    load_text("+.");
    send_buffer(1'b1);
    load_text("-");
    send_buffer(1'b1);
    load_text("7");
    send_buffer(1'b1);
  endtask

  task automatic test_malformed_text();
    load_text("1..2");
    send_buffer(1'b1);
    load_text("1-");
    send_buffer(1'b1);
    text_buf.push_back(CHAR_SPACE);
    send_buffer(1'b1);
    text_buf.push_back(8'hFF);
    send_buffer(1'b1);
    text_buf.push_back(8'h00);
    send_buffer(1'b1);
  endtask

  // signed limit at zero places, overflow while padding at clamped places
  task automatic test_range_limits();
    write_places(4'd0);
    load_text("-2147483648");
    send_buffer(1'b1);
    load_text("2147483648");
    send_buffer(1'b1);
    write_places(4'd15);
    load_text("3");
    send_buffer(1'b1);
    load_text("-2.1");
    send_buffer(1'b1);
  endtask

  // places lowered while a number is open
  task automatic test_mid_number_change();
    write_places(4'd3);
    load_text("7.125");
    send_buffer(1'b0);
    write_places(4'd1);
    load_text("9");
    send_buffer(1'b1);
  endtask

  task automatic test_random_numbers();
    logic [FD_W-1:0] settings [PHASES];
    int unsigned     phase_start;
    bit              paused;
    settings = '{4'd0, 4'd9, 4'd15, 4'd3, 4'd0, 4'd0};
    settings[4] = FD_W'($urandom_range(15, 0));
    settings[5] = FD_W'($urandom_range(9, 0));
    paused = 1'b0;
    foreach (settings[p]) begin
      write_places(settings[p]);
      src_idle_en  = (p != 3);
      sink_idle_en = (p != 3);
      phase_start  = chars_sent;
      while (chars_sent - phase_start < RANDOM_CHARS / PHASES) begin
        if (p == 1 && !paused && chars_sent - phase_start >= RANDOM_CHARS / (2 * PHASES)) begin
          drain_results();
          paused = 1'b1;
        end
        build_random_number();
        send_buffer(1'b1);
      end
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_places();
    test_malformed_text();
    test_range_limits();
    test_mid_number_change();
    test_random_numbers();
    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
